>>> rtl/core/rgbpwm_pkg.sv
// Shared types, constants and helpers for the RGB PWM breathing LED driver.
// No dependencies; imported by every module of the block.
package rgbpwm_pkg;

  localparam logic [7:0]  LEVEL_MAX = 8'd100;

  // Reset values of the configuration registers
  localparam logic [7:0]  PWM_TOP_RST          = 8'd100;
  localparam logic [15:0] BREATHE_INTERVAL_RST = 16'd50;
  localparam logic [6:0]  BREATHE_PEAK_RST     = 7'd100;
  localparam logic        BREATHE_ENABLE_RST   = 1'b1;

  typedef enum logic [2:0] {
    OP_TICK       = 3'd0,
    OP_SET_LEVELS = 3'd1,
    OP_BREATHE    = 3'd2,
    OP_ON         = 3'd3,
    OP_OFF        = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    REG_PWM_TOP          = 2'd0,
    REG_BREATHE_INTERVAL = 2'd1,
    REG_BREATHE_PEAK     = 2'd2,
    REG_BREATHE_ENABLE   = 2'd3
  } reg_index_t;

  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;

  typedef struct packed {
    logic [7:0]  pwm_top;
    logic [15:0] breathe_interval;
    logic [6:0]  breathe_peak;
    logic        breathe_enable;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [7:0]  red_level;
    logic [7:0]  green_level;
    logic [7:0]  blue_level;
    logic [1:0]  breathe_channel_sel;
    logic [15:0] loop_count;
  } item_t;

  function automatic logic [7:0] clamp_level(input logic [7:0] v);
    return (v > LEVEL_MAX) ? LEVEL_MAX : v;
  endfunction

endpackage

>>> rtl/core/rgbpwm_cfg.sv
// APB-style configuration registers of the RGB PWM breathing LED driver.
// Depends on rgbpwm_pkg for the register map and the cfg_t bundle.
module rgbpwm_cfg
  import rgbpwm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic       wr_en;
  reg_index_t reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = reg_index_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pwm_top          <= PWM_TOP_RST;
      cfg.breathe_interval <= BREATHE_INTERVAL_RST;
      cfg.breathe_peak     <= BREATHE_PEAK_RST;
      cfg.breathe_enable   <= BREATHE_ENABLE_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_PWM_TOP:          cfg.pwm_top          <= pwdata[7:0];
        REG_BREATHE_INTERVAL: cfg.breathe_interval <= pwdata[15:0];
        REG_BREATHE_PEAK:     cfg.breathe_peak     <= pwdata[6:0];
        REG_BREATHE_ENABLE:   cfg.breathe_enable   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_PWM_TOP:          prdata = {24'd0, cfg.pwm_top};
      REG_BREATHE_INTERVAL: prdata = {16'd0, cfg.breathe_interval};
      REG_BREATHE_PEAK:     prdata = {25'd0, cfg.breathe_peak};
      REG_BREATHE_ENABLE:   prdata = {31'd0, cfg.breathe_enable};
      default:              prdata = 32'd0;
    endcase
  end

endmodule

>>> rtl/core/rgbpwm_engine.sv
// Driver state and single-pass item logic: breathing ramp, loop count, PWM compare.
// Depends on rgbpwm_pkg; the top level feeds it registered items and the config bundle.
module rgbpwm_engine
  import rgbpwm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  item_t      item,
  input  cfg_t       cfg,
  output logic [2:0] pins_next,
  output logic       on_next
);

  logic        on_flag;
  logic [7:0]  pwm_count, pwm_count_next;
  logic [7:0]  duty_r, duty_g, duty_b;
  logic [7:0]  duty_r_next, duty_g_next, duty_b_next;
  logic [2:0]  pins;
  logic [15:0] interval_count, interval_count_next;
  logic [8:0]  ramp_position, ramp_position_next;
  logic [15:0] loops_left, loops_left_next;
  logic [1:0]  breathe_channel, breathe_channel_next;

  logic [15:0] ic_inc;
  logic [8:0]  rp_inc;
  logic [8:0]  peak9, peak2;
  logic [8:0]  level9;
  logic [7:0]  level;
  logic        load_levels;

  assign ic_inc = interval_count + 16'd1;
  assign rp_inc = ramp_position + 9'd1;
  assign peak9  = {2'b00, cfg.breathe_peak};
  assign peak2  = {1'b0, cfg.breathe_peak, 1'b0};

  // Triangle: rise up to the peak, fall back over the second half
  always_comb begin
    if (cfg.breathe_peak == 7'd0) begin
      level9 = 9'd0;
    end else if (ramp_position_next < peak9) begin
      level9 = ramp_position_next;
    end else begin
      level9 = peak2 - ramp_position_next;
    end
    level = clamp_level(level9[7:0]);
  end

  always_comb begin
    on_next              = on_flag;
    pwm_count_next       = pwm_count;
    duty_r_next          = duty_r;
    duty_g_next          = duty_g;
    duty_b_next          = duty_b;
    pins_next            = pins;
    interval_count_next  = interval_count;
    ramp_position_next   = ramp_position;
    loops_left_next      = loops_left;
    breathe_channel_next = breathe_channel;
    load_levels          = 1'b0;
    case (item.opcode)
      OP_TICK: begin
        if (cfg.breathe_enable && on_flag) begin
          if (ic_inc <= cfg.breathe_interval) begin
            interval_count_next = ic_inc;
          end else begin
            interval_count_next = 16'd0;
            ramp_position_next  = rp_inc;
            load_levels         = 1'b1;
            if (rp_inc >= peak2) begin
              ramp_position_next = 9'd0;
              if (loops_left != 16'd0) begin
                loops_left_next = loops_left - 16'd1;
                // last loop done: go dark and keep the levels
                if (loops_left == 16'd1) begin
                  on_next     = 1'b0;
                  load_levels = 1'b0;
                end
              end
            end
          end
        end
        if (load_levels) begin
          duty_r_next = 8'd0;
          duty_g_next = 8'd0;
          duty_b_next = 8'd0;
          case (breathe_channel)
            CH_RED:   duty_r_next = level;
            CH_GREEN: duty_g_next = level;
            default:  duty_b_next = level;
          endcase
        end
        if (!on_next) begin
          pins_next = 3'b000;
        end else begin
          pins_next = {pwm_count < duty_b_next, pwm_count < duty_g_next,
                       pwm_count < duty_r_next};
          pwm_count_next = (pwm_count < cfg.pwm_top) ? pwm_count + 8'd1 : 8'd0;
        end
      end
      OP_SET_LEVELS: begin
        duty_r_next = clamp_level(item.red_level);
        duty_g_next = clamp_level(item.green_level);
        duty_b_next = clamp_level(item.blue_level);
      end
      OP_BREATHE: begin
        on_next              = 1'b1;
        breathe_channel_next = item.breathe_channel_sel;
        loops_left_next      = item.loop_count;
      end
      OP_ON:   on_next = 1'b1;
      OP_OFF:  on_next = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      on_flag         <= 1'b0;
      pwm_count       <= 8'd0;
      duty_r          <= 8'd0;
      duty_g          <= 8'd0;
      duty_b          <= 8'd0;
      pins            <= 3'b000;
      interval_count  <= 16'd0;
      ramp_position   <= 9'd0;
      loops_left      <= 16'd0;
      breathe_channel <= CH_GREEN;
    end else if (advance) begin
      on_flag         <= on_next;
      pwm_count       <= pwm_count_next;
      duty_r          <= duty_r_next;
      duty_g          <= duty_g_next;
      duty_b          <= duty_b_next;
      pins            <= pins_next;
      interval_count  <= interval_count_next;
      ramp_position   <= ramp_position_next;
      loops_left      <= loops_left_next;
      breathe_channel <= breathe_channel_next;
    end
  end

  a_duty_clamped: assert property (@(posedge clk) disable iff (rst)
    duty_r <= LEVEL_MAX && duty_g <= LEVEL_MAX && duty_b <= LEVEL_MAX)
    else $error("duty level above LEVEL_MAX");

  a_dark_tick_pins_low: assert property (@(posedge clk) disable iff (rst)
    advance && item.opcode == OP_TICK && !on_next |=> pins == 3'b000)
    else $error("pins not cleared on a dark tick");

  a_count_holds_off_tick: assert property (@(posedge clk) disable iff (rst)
    advance && item.opcode != OP_TICK |=> $stable(pwm_count))
    else $error("pwm counter moved on a non-tick item");

endmodule

>>> rtl/core/rgb_pwm_breathing_led.sv
// Three-channel PWM LED driver with breathing effect: stream ports, input and result registers.
// Depends on rgbpwm_pkg, rgbpwm_cfg and rgbpwm_engine.
//
// Each item is an opcode on s_tuser (tick, set levels, start breathing, on, off) with its
// operands on s_tdata; each item yields exactly one result item giving the three pin levels
// and the lit flag afterwards. The block takes one item every clock cycle: an item is held in
// the input register, its whole update is one pass of logic into the state and the result
// register, and its result is offered on m_tdata from there. Throughput drops only when the
// result register is full and m_tready is low. Write the registers over APB only while the
// block is idle.
module rgb_pwm_breathing_led
  import rgbpwm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // red_level[7:0], green_level[15:8], blue_level[23:16],
                                 // breathe_channel_sel[25:24], loop_count[41:26], zeros[47:42]
  input  logic [2:0]  s_tuser,   // opcode[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // red_on[0], green_on[1], blue_on[2], lit[3], zeros[7:4]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t       cfg;
  item_t      item_q;
  logic       in_valid;
  logic       advance;
  logic [2:0] pins_next;
  logic       on_next;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item_q.opcode              <= s_tuser;
      item_q.red_level           <= s_tdata[7:0];
      item_q.green_level         <= s_tdata[15:8];
      item_q.blue_level          <= s_tdata[23:16];
      item_q.breathe_channel_sel <= s_tdata[25:24];
      item_q.loop_count          <= s_tdata[41:26];
    end
  end

  rgbpwm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rgbpwm_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .item      (item_q),
    .cfg       (cfg),
    .pins_next (pins_next),
    .on_next   (on_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {4'b0000, on_next, pins_next};
    end
  end

endmodule

>>> verif/rgb_pwm_breathing_led_tb.sv
// Self-checking testbench for rgb_pwm_breathing_led: stream driver, stream monitor and APB writes.
// Predicts pin levels and the lit flag per item and compares them in order.
// Depends on rgbpwm_pkg and the rgb_pwm_breathing_led RTL.
`timescale 1ns / 100ps

module rgb_pwm_breathing_led_tb;
  import rgbpwm_pkg::*;

  localparam int IDLE_LIMIT  = 2000;
  localparam int LONG_HOLD   = 150;
  localparam int MAX_REPORTS = 10;
  localparam int NUM_PHASES  = 11;
  localparam int PHASE_ITEMS = 158;
  localparam logic [2:0] OP_LAST_CODE = 3'd7;

  typedef struct {
    bit red_on;
    bit green_on;
    bit blue_on;
    bit lit;
  } pin_report_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata  = '0;
  logic [2:0]  s_tuser  = OP_TICK;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [3:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  rgb_pwm_breathing_led uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  initial forever #10 clk = ~clk;

  item_t       led_cmds_pending[$];
  pin_report_t pin_reports_due[$];
  int          mismatches = 0;

  // Shadow configuration and state of the LED driver
  bit [7:0]  period_cfg;
  bit [15:0] interval_cfg;
  bit [6:0]  peak_cfg;
  bit        enable_cfg;
  bit        led_on;
  bit [7:0]  pwm_phase;
  bit [7:0]  duty [3];
  bit [2:0]  pins;
  bit [15:0] step_prescale;
  bit [8:0]  ramp_pos;
  bit [15:0] loops_left;
  bit [1:0]  breathe_ch;

  function automatic bit [7:0] limit_duty(bit [7:0] v);
    return (v > LEVEL_MAX) ? LEVEL_MAX : v;
  endfunction

  function automatic void breathe_tick();
    int level;
    if (!led_on) return;
    step_prescale = step_prescale + 1'b1;
    if (step_prescale <= interval_cfg) return;
    step_prescale = '0;
    ramp_pos = ramp_pos + 1'b1;
    if (ramp_pos >= {peak_cfg, 1'b0}) begin
      ramp_pos = '0;
      if (loops_left > 0) begin
        loops_left = loops_left - 1'b1;
        // last loop done: go dark without touching the levels
        if (loops_left == 0) begin
          led_on = 1'b0;
          return;
        end
      end
    end
    if (peak_cfg == 0)
      level = 0;
    else if (ramp_pos < peak_cfg)
      level = ramp_pos;
    else
      level = int'(peak_cfg) - (int'(ramp_pos) - int'(peak_cfg));
    duty[0] = '0;
    duty[1] = '0;
    duty[2] = '0;
    case (breathe_ch)
      CH_RED:   duty[0] = limit_duty(8'(level));
      CH_GREEN: duty[1] = limit_duty(8'(level));
      default:  duty[2] = limit_duty(8'(level));
    endcase
  endfunction

  function automatic void pwm_tick();
    if (!led_on) begin
      pins = '0;
      return;
    end
    pins[0] = pwm_phase < duty[0];
    pins[1] = pwm_phase < duty[1];
    pins[2] = pwm_phase < duty[2];
    pwm_phase = (pwm_phase < period_cfg) ? pwm_phase + 1'b1 : 8'd0;
  endfunction

  function automatic pin_report_t led_model_step(logic [2:0] op, logic [47:0] data);
    pin_report_t r;
    case (op)
      OP_TICK: begin
        if (enable_cfg) breathe_tick();
        pwm_tick();
      end
      OP_SET_LEVELS: begin
        duty[0] = limit_duty(data[7:0]);
        duty[1] = limit_duty(data[15:8]);
        duty[2] = limit_duty(data[23:16]);
      end
      OP_BREATHE: begin
        led_on     = 1'b1;
        breathe_ch = data[25:24];
        loops_left = data[41:26];
      end
      OP_ON:  led_on = 1'b1;
      OP_OFF: led_on = 1'b0;
      default: ;
    endcase
    r = '{pins[0], pins[1], pins[2], led_on};
    return r;
  endfunction

  function automatic void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("mismatch: %s", msg);
  endfunction

  function automatic item_t random_cmd(logic [2:0] op);
    item_t c;
    c.opcode              = op;
    c.red_level           = 8'($urandom_range(0, 255));
    c.green_level         = 8'($urandom_range(0, 255));
    c.blue_level          = 8'($urandom_range(0, 255));
    c.breathe_channel_sel = 2'($urandom_range(0, 3));
    c.loop_count = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
    return c;
  endfunction

  function automatic void queue_cmd(logic [2:0] op, logic [7:0] r, logic [7:0] g,
                                    logic [7:0] b, logic [1:0] sel, logic [15:0] loops);
    item_t c;
    c = '{op, r, g, b, sel, loops};
    led_cmds_pending.push_back(c);
  endfunction

  // Mostly breathing runs and static runs followed by ticks; the rest is noise.
  task automatic queue_random_phase(int n);
    int queued;
    int k;
    logic [2:0] op;
    queued = 0;
    while (queued < n) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          led_cmds_pending.push_back(random_cmd(OP_BREATHE));
          k = $urandom_range(4, 40);
          repeat (k) led_cmds_pending.push_back(random_cmd(OP_TICK));
          queued += k + 1;
        end
        6, 7: begin
          led_cmds_pending.push_back(random_cmd(OP_SET_LEVELS));
          led_cmds_pending.push_back(random_cmd(OP_ON));
          k = $urandom_range(2, 30);
          repeat (k) led_cmds_pending.push_back(random_cmd(OP_TICK));
          queued += k + 2;
        end
        default: begin
          repeat (3) begin
            if ($urandom_range(0, 9) == 0)
              op = 3'($urandom_range(OP_OFF + 1, OP_LAST_CODE));
            else
              op = 3'($urandom_range(OP_TICK, OP_OFF));
            led_cmds_pending.push_back(random_cmd(op));
            if (op <= OP_OFF) queued++;
          end
        end
      endcase
    end
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_PWM_TOP:          period_cfg   = value[7:0];
      REG_BREATHE_INTERVAL: interval_cfg = value[15:0];
      REG_BREATHE_PEAK:     peak_cfg     = value[6:0];
      default:              enable_cfg   = value[0];
    endcase
  endtask

  task automatic configure_phase(int phase);
    logic [31:0] period;
    logic [31:0] interval;
    logic [31:0] peak;
    case (phase % 4)
      0: period = 1;
      1: period = 255;
      2: period = $urandom_range(1, 10);
      default: period = $urandom_range(1, 255);
    endcase
    case (phase % 5)
      0: interval = 0;
      1: interval = 65534;
      2, 3: interval = $urandom_range(0, 3);
      default: interval = $urandom_range(0, 300);
    endcase
    case ((phase + 1) % 4)
      0: peak = 1;
      1: peak = 100;
      2: peak = $urandom_range(1, 6);
      default: peak = $urandom_range(1, 100);
    endcase
    write_reg(REG_PWM_TOP, period);
    write_reg(REG_BREATHE_INTERVAL, interval);
    write_reg(REG_BREATHE_PEAK, peak);
    write_reg(REG_BREATHE_ENABLE, (phase % 6 == 5) ? 32'd0 : 32'd1);
  endtask

  task automatic drain();
    while (led_cmds_pending.size() != 0 || s_tvalid || pin_reports_due.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Sender: bursts of random length separated by random gaps
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin : drive_items
    item_t cmd;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_tvalid <= 1'b0;
      end else if (led_cmds_pending.size() != 0) begin
        cmd = led_cmds_pending.pop_front();
        s_tvalid <= 1'b1;
        s_tuser  <= cmd.opcode;
        s_tdata  <= {6'b0, cmd.loop_count, cmd.breathe_channel_sel,
                     cmd.blue_level, cmd.green_level, cmd.red_level};
        if (burst_left > 0) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(0, 40);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern is picked anew when the 6-bit ready_cycle counter wraps, plus one long hold on request
  logic       hold_request = 1'b0;
  logic       hold_served  = 1'b0;
  int         hold_left    = 0;
  logic [5:0] ready_cycle  = '0;
  int         ready_mode   = 0;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      ready_cycle <= ready_cycle + 1'b1;
      if (hold_request && !hold_served) begin
        hold_served <= 1'b1;
        hold_left   <= LONG_HOLD;
        m_tready    <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        m_tready  <= 1'b0;
      end else begin
        if (ready_cycle == 0) ready_mode <= $urandom_range(0, 3);
        case (ready_mode)
          0: m_tready <= 1'b1;
          1: m_tready <= ($urandom_range(0, 3) != 0);
          2: m_tready <= ($urandom_range(0, 2) == 0);
          default: m_tready <= ready_cycle[2];
        endcase
      end
    end
  end

  // Predict on input acceptance first, then check the result accepted at the same edge
  always @(posedge clk) begin : check_items
    pin_report_t due;
    if (!rst) begin
      if (s_tvalid && s_tready) pin_reports_due.push_back(led_model_step(s_tuser, s_tdata));
      if (m_tvalid && m_tready) begin
        if (pin_reports_due.size() == 0) begin
          note_mismatch($sformatf("result with none expected, tdata %b", m_tdata));
        end else begin
          due = pin_reports_due.pop_front();
          if (m_tdata[0] !== due.red_on || m_tdata[1] !== due.green_on ||
              m_tdata[2] !== due.blue_on || m_tdata[3] !== due.lit || m_tdata[7:4] !== 4'b0)
            note_mismatch($sformatf(
              "expected r %0b g %0b b %0b lit %0b, got r %b g %b b %b lit %b pad %b",
              due.red_on, due.green_on, due.blue_on, due.lit,
              m_tdata[0], m_tdata[1], m_tdata[2], m_tdata[3], m_tdata[7:4]));
        end
      end
    end
  end

  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                 (psel && penable && pwrite && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("rgb_pwm_breathing_led_tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    period_cfg    = PWM_TOP_RST;
    interval_cfg  = BREATHE_INTERVAL_RST;
    peak_cfg      = BREATHE_PEAK_RST;
    enable_cfg    = BREATHE_ENABLE_RST;
    led_on        = 1'b0;
    pwm_phase     = '0;
    duty          = '{8'd0, 8'd0, 8'd0};
    pins          = '0;
    step_prescale = '0;
    ramp_pos      = '0;
    loops_left    = '0;
    breathe_ch    = CH_GREEN;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed items at the reset configuration
    queue_cmd(OP_TICK, 8'd0, 8'd0, 8'd0, 2'd0, 16'd0);         // dark tick holds pins low
    queue_cmd(OP_SET_LEVELS, 8'd255, LEVEL_MAX, 8'd0, 2'd0, 16'd0);
    queue_cmd(OP_ON, 8'd0, 8'd0, 8'd0, 2'd0, 16'd0);
    queue_cmd(OP_TICK, 8'd0, 8'd0, 8'd0, 2'd0, 16'd0);
    queue_cmd(OP_TICK, 8'hff, 8'hff, 8'hff, 2'd3, 16'hffff);
    queue_cmd(OP_SET_LEVELS, LEVEL_MAX + 8'd1, LEVEL_MAX - 8'd1, 8'd1, 2'd0, 16'd0);
    queue_cmd(OP_TICK, 8'd0, 8'd0, 8'd0, 2'd0, 16'd0);
    queue_cmd(OP_OFF, 8'd0, 8'd0, 8'd0, 2'd0, 16'd0);          // pins keep their values
    queue_cmd(OP_TICK, 8'd0, 8'd0, 8'd0, 2'd0, 16'd0);
    queue_cmd(OP_OFF + 3'd1, 8'hff, 8'hff, 8'hff, 2'd3, 16'hffff);
    queue_cmd(OP_OFF + 3'd2, 8'hff, 8'hff, 8'hff, 2'd3, 16'hffff);
    queue_cmd(OP_LAST_CODE, 8'h55, 8'haa, 8'h0f, 2'd1, 16'h5a5a);
    queue_cmd(OP_BREATHE, 8'd0, 8'd0, 8'd0, CH_RED, 16'd1);
    repeat (3) queue_cmd(OP_TICK, 8'd0, 8'd0, 8'd0, 2'd0, 16'd0);
    queue_cmd(OP_BREATHE, 8'd0, 8'd0, 8'd0, 2'd3, 16'hffff);
    queue_cmd(OP_TICK, 8'd0, 8'd0, 8'd0, 2'd0, 16'd0);
    queue_cmd(OP_BREATHE, 8'd0, 8'd0, 8'd0, 2'd2, 16'd0);
    queue_cmd(OP_ON, 8'd0, 8'd0, 8'd0, 2'd0, 16'd0);
    queue_cmd(OP_SET_LEVELS, 8'd0, 8'd0, 8'd0, 2'd0, 16'd0);
    queue_cmd(OP_TICK, 8'd0, 8'd0, 8'd0, 2'd0, 16'd0);
    queue_cmd(OP_BREATHE, 8'd0, 8'd0, 8'd0, CH_GREEN, 16'd2);
    queue_cmd(OP_TICK, 8'd0, 8'd0, 8'd0, 2'd0, 16'd0);
    queue_cmd(OP_OFF, 8'd0, 8'd0, 8'd0, 2'd0, 16'd0);
    drain();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      configure_phase(phase);
      // fill the block while the receiver holds off
      if (phase == 2) hold_request <= 1'b1;
      queue_random_phase(PHASE_ITEMS);
      drain();
    end

    repeat (10) @(posedge clk);
    if (pin_reports_due.size() != 0)
      note_mismatch($sformatf("%0d results never arrived", pin_reports_due.size()));
    if (mismatches == 0)
      $display("rgb_pwm_breathing_led_tb passed");
    else
      $display("rgb_pwm_breathing_led_tb failed");
    $finish;
  end

endmodule
